// ===== rtl/core/npsu_pkg.sv =====
// Shared constants and types for the nonpreemptive priority scheduler.
`default_nettype none
package npsu_pkg;

    localparam int MAX_PROCS     = 16;
    localparam int TIME_BITS     = 16;
    localparam int PRIORITY_BITS = 8;

    localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W = $clog2(MAX_PROCS + 1);

    localparam int PID_W  = 5;
    localparam int CT_W   = 21;
    localparam int DUR_W  = 20;
    localparam int SUM_W  = 24;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 160;

    typedef struct packed {
        logic                     en;
        logic [IDX_W-1:0]         idx;
        logic [TIME_BITS-1:0]     arr;
        logic [TIME_BITS-1:0]     burst;
        logic [PRIORITY_BITS-1:0] prio;
    } store_wr_t;

    typedef struct packed {
        logic                     set;
        logic [IDX_W-1:0]         idx;
        logic                     clr_all;
    } fin_ctrl_t;

    typedef struct packed {
        logic [TIME_BITS-1:0]     arr;
        logic [TIME_BITS-1:0]     burst;
        logic [PRIORITY_BITS-1:0] prio;
        logic                     fin;
    } entry_t;

    typedef struct packed {
        logic             clr;
        logic             step;
        logic [IDX_W-1:0] idx;
    } scan_ctrl_t;

    typedef struct packed {
        logic                     found;
        logic [IDX_W-1:0]         idx;
        logic [TIME_BITS-1:0]     arr;
        logic [TIME_BITS-1:0]     burst;
        logic                     any;
        logic [TIME_BITS-1:0]     min_arr;
    } scan_res_t;

endpackage
`default_nettype wire

// ===== rtl/core/npsu_store.sv =====
// Job store: arrival, burst and priority per slot plus finished flags.
`default_nettype none
module npsu_store
    import npsu_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire store_wr_t wr,
    input  wire fin_ctrl_t fin_ctrl,
    input  wire logic [IDX_W-1:0] rd_idx,
    output entry_t         rd
);

    logic [TIME_BITS-1:0]     arr_mem   [MAX_PROCS];
    logic [TIME_BITS-1:0]     burst_mem [MAX_PROCS];
    logic [PRIORITY_BITS-1:0] prio_mem  [MAX_PROCS];
    logic [MAX_PROCS-1:0]     fin_reg;
    logic [MAX_PROCS-1:0]     fin_next;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            arr_mem[wr.idx]   <= wr.arr;
            burst_mem[wr.idx] <= wr.burst;
            prio_mem[wr.idx]  <= wr.prio;
        end
    end

    always_comb
    begin
        fin_next = fin_reg;
        if (fin_ctrl.clr_all)
        begin
            fin_next = '0;
        end
        else
        begin
            if (fin_ctrl.set)
            begin
                fin_next[fin_ctrl.idx] = 1'b1;
            end
            if (wr.en)
            begin
                fin_next[wr.idx] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_reg <= '0;
        end
        else
        begin
            fin_reg <= fin_next;
        end
    end

    assign rd.arr   = arr_mem[rd_idx];
    assign rd.burst = burst_mem[rd_idx];
    assign rd.prio  = prio_mem[rd_idx];
    assign rd.fin   = fin_reg[rd_idx];

endmodule
`default_nettype wire

// ===== rtl/core/npsu_scan.sv =====
// Shared compare unit: one stored job per step, tracks best ready job and earliest arrival.
`default_nettype none
module npsu_scan
    import npsu_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire scan_ctrl_t       ctrl,
    input  wire entry_t           entry,
    input  wire logic [CT_W-1:0]  cur_time,
    output scan_res_t             res
);

    scan_res_t res_reg;
    scan_res_t res_next;
    logic      ready;
    logic      better;

    logic [PRIORITY_BITS-1:0] prio_reg;
    logic [PRIORITY_BITS-1:0] prio_next;

    always_comb
    begin
        ready  = !entry.fin && ({{(CT_W-TIME_BITS){1'b0}}, entry.arr} <= cur_time);
        better = !res_reg.found
              || (entry.prio < prio_reg)
              || ((entry.prio == prio_reg) && (entry.arr < res_reg.arr));
    end

    always_comb
    begin
        res_next  = res_reg;
        prio_next = prio_reg;
        if (ctrl.clr)
        begin
            res_next.found = 1'b0;
            res_next.any   = 1'b0;
        end
        else if (ctrl.step)
        begin
            if (ready && better)
            begin
                res_next.found = 1'b1;
                res_next.idx   = ctrl.idx;
                res_next.arr   = entry.arr;
                res_next.burst = entry.burst;
                prio_next      = entry.prio;
            end
            if (!entry.fin && (!res_reg.any || (entry.arr < res_reg.min_arr)))
            begin
                res_next.any     = 1'b1;
                res_next.min_arr = entry.arr;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg  <= '0;
            prio_reg <= '0;
        end
        else
        begin
            res_reg  <= res_next;
            prio_reg <= prio_next;
        end
    end

    assign res = res_reg;

endmodule
`default_nettype wire

// ===== rtl/core/nonpreemptive_priority_scheduler_unit.sv =====
// Top level: job loading, dispatch sequencer and result register.
// Load: one job per cycle while s_tready is high; tlast starts the schedule.
// Per dispatched job: a scan over the stored jobs, then decide, compute and result (the result
// waits while the output is stalled); when no job is ready, time jumps and the scan repeats.
// Reset (rst_n low, asynchronous) empties the store, clears time, sums and flags.
`default_nettype none
module nonpreemptive_priority_scheduler_unit
    import npsu_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // arrival_time[15:0], burst_time[31:16], priority_req[39:32]
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic                  s_tlast,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // process_id[4:0], start_time[25:5], completion_time[46:26], turnaround_time[66:47],
    // waiting_time[86:67], response_time[106:87], total_turnaround[130:107],
    // total_waiting[154:131], zero fill[159:155]
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic                       m_tlast
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_CALC   = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    logic [2:0]       state_reg,  state_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic [CNT_W-1:0] done_reg,   done_next;
    logic [IDX_W-1:0] idx_reg,    idx_next;
    logic [CT_W-1:0]  cur_reg,    cur_next;
    logic [SUM_W-1:0] tsum_reg,   tsum_next;
    logic [SUM_W-1:0] wsum_reg,   wsum_next;
    logic [CT_W-1:0]  finish_reg, finish_next;
    logic [DUR_W-1:0] rt_reg,     rt_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg,  m_tdata_next;
    logic                  m_tlast_reg,  m_tlast_next;

    store_wr_t  wr;
    fin_ctrl_t  fin_ctrl;
    entry_t     entry;
    scan_ctrl_t scan_ctrl;
    scan_res_t  res;

    logic             in_xfer;
    logic             out_free;
    logic             last_job;
    logic [CT_W-1:0]  arr_ext;
    logic [CT_W-1:0]  tat_full;
    logic [DUR_W-1:0] tat;
    logic [SUM_W-1:0] tsum_new;
    logic [SUM_W-1:0] wsum_new;

    npsu_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .fin_ctrl (fin_ctrl),
        .rd_idx   (idx_reg),
        .rd       (entry)
    );

    npsu_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (scan_ctrl),
        .entry    (entry),
        .cur_time (cur_reg),
        .res      (res)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign last_job = ((done_reg + CNT_W'(1)) == count_reg);
    assign arr_ext  = {{(CT_W-TIME_BITS){1'b0}}, res.arr};
    assign tat_full = finish_reg - arr_ext;
    assign tat      = tat_full[DUR_W-1:0];
    assign tsum_new = tsum_reg + {{(SUM_W-DUR_W){1'b0}}, tat};
    assign wsum_new = wsum_reg + {{(SUM_W-DUR_W){1'b0}}, rt_reg};

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        done_next     = done_reg;
        idx_next      = idx_reg;
        cur_next      = cur_reg;
        tsum_next     = tsum_reg;
        wsum_next     = wsum_reg;
        finish_next   = finish_reg;
        rt_next       = rt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;

        wr.en    = 1'b0;
        wr.idx   = count_reg[IDX_W-1:0];
        wr.arr   = s_tdata[TIME_BITS-1:0];
        wr.burst = s_tdata[2*TIME_BITS-1:TIME_BITS];
        wr.prio  = s_tdata[2*TIME_BITS+PRIORITY_BITS-1:2*TIME_BITS];

        fin_ctrl.set     = 1'b0;
        fin_ctrl.idx     = res.idx;
        fin_ctrl.clr_all = 1'b0;

        scan_ctrl.clr  = 1'b0;
        scan_ctrl.step = 1'b0;
        scan_ctrl.idx  = idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (count_reg < CNT_W'(MAX_PROCS))
                    begin
                        wr.en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (s_tlast)
                    begin
                        scan_ctrl.clr = 1'b1;
                        idx_next      = '0;
                        done_next     = '0;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                scan_ctrl.step = 1'b1;
                if (CNT_W'(idx_reg) == (count_reg - CNT_W'(1)))
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_DECIDE:
            begin
                if (res.found)
                begin
                    state_next = ST_CALC;
                end
                else if (res.any)
                begin
                    cur_next      = {{(CT_W-TIME_BITS){1'b0}}, res.min_arr};
                    scan_ctrl.clr = 1'b1;
                    idx_next      = '0;
                    state_next    = ST_SCAN;
                end
                else
                begin
                    fin_ctrl.clr_all = 1'b1;
                    count_next       = '0;
                    cur_next         = '0;
                    tsum_next        = '0;
                    wsum_next        = '0;
                    state_next       = ST_IDLE;
                end
            end
            ST_CALC:
            begin
                finish_next = cur_reg + {{(CT_W-TIME_BITS){1'b0}}, res.burst};
                rt_next     = DUR_W'(cur_reg - arr_ext);
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = last_job;
                    m_tdata_next  = {
                        {(OUT_DATA_W-155){1'b0}},
                        (last_job ? wsum_new : {SUM_W{1'b0}}),
                        (last_job ? tsum_new : {SUM_W{1'b0}}),
                        rt_reg,
                        rt_reg,
                        tat,
                        finish_reg,
                        cur_reg,
                        PID_W'(res.idx) + PID_W'(1)
                    };
                    fin_ctrl.set = 1'b1;
                    if (last_job)
                    begin
                        fin_ctrl.clr_all = 1'b1;
                        count_next       = '0;
                        done_next        = '0;
                        cur_next         = '0;
                        tsum_next        = '0;
                        wsum_next        = '0;
                        state_next       = ST_IDLE;
                    end
                    else
                    begin
                        done_next     = done_reg + CNT_W'(1);
                        cur_next      = finish_reg;
                        tsum_next     = tsum_new;
                        wsum_next     = wsum_new;
                        scan_ctrl.clr = 1'b1;
                        idx_next      = '0;
                        state_next    = ST_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            done_reg     <= '0;
            idx_reg      <= '0;
            cur_reg      <= '0;
            tsum_reg     <= '0;
            wsum_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            done_reg     <= done_next;
            idx_reg      <= idx_next;
            cur_reg      <= cur_next;
            tsum_reg     <= tsum_next;
            wsum_reg     <= wsum_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        finish_reg  <= finish_next;
        rt_reg      <= rt_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
`default_nettype wire

// ===== rtl/core/npsu_checker.sv =====
// Port-level checks for the scheduler, bound to the top level.
`default_nettype none
module npsu_checker
    import npsu_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic [IN_DATA_W-1:0]  s_tdata,
    input wire logic                  s_tlast,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata,
    input wire logic                  m_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken right after final job");

    a_totals_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[154:107] == 48'd0)
        else $error("totals set on a non-final result");

    a_wait_eq_resp: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[86:67] == m_tdata[106:87]) && (m_tdata[4:0] != 5'd0))
        else $error("waiting and response differ or job number is zero");

endmodule

bind nonpreemptive_priority_scheduler_unit npsu_checker u_npsu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire

// ===== tb/npsu_schedule_checker.sv =====
// Checker for the priority scheduler: predicts each job set's schedule and compares results.
module npsu_schedule_checker
    import npsu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  m_tlast,
    output int unsigned           fail_count,
    output int unsigned           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [PID_W-1:0] pid;
        logic [CT_W-1:0]  started;
        logic [CT_W-1:0]  completed;
        logic [DUR_W-1:0] turnaround;
        logic [DUR_W-1:0] waiting;
        logic [DUR_W-1:0] response;
        logic [SUM_W-1:0] turnaround_total;
        logic [SUM_W-1:0] waiting_total;
        logic             last;
    } dispatch_t;

    logic [TIME_BITS-1:0]     job_arrival [MAX_PROCS];
    logic [TIME_BITS-1:0]     job_burst   [MAX_PROCS];
    logic [PRIORITY_BITS-1:0] job_prio    [MAX_PROCS];
    bit                       job_done    [MAX_PROCS];
    int unsigned              job_total;
    dispatch_t                predicted_dispatches [$];

    function automatic bit ranks_ahead(int a, int b);
        if (job_prio[a] != job_prio[b])
            return job_prio[a] < job_prio[b];
        return job_arrival[a] < job_arrival[b];
    endfunction

    // lowest index wins ties since only a strictly better job replaces the pick
    function automatic int pick_ready(longint unsigned now);
        int pick;
        pick = -1;
        for (int i = 0; i < job_total; i++)
            if (!job_done[i] && job_arrival[i] <= now)
                if (pick < 0 || ranks_ahead(i, pick))
                    pick = i;
        return pick;
    endfunction

    function automatic void schedule_job_set();
        longint unsigned now, t_start, t_end, tat, wt, tat_sum, wt_sum, next_arr;
        int              pick;
        bit              found;
        dispatch_t       d;
        dispatch_t       set_q [$];
        now     = 0;
        tat_sum = 0;
        wt_sum  = 0;
        for (int k = 0; k < job_total; k++)
        begin
            pick = pick_ready(now);
            if (pick < 0)
            begin
                // idle: jump to the earliest unfinished arrival
                found    = 0;
                next_arr = 0;
                for (int i = 0; i < job_total; i++)
                    if (!job_done[i] && (!found || job_arrival[i] < next_arr))
                    begin
                        next_arr = job_arrival[i];
                        found    = 1;
                    end
                now  = next_arr;
                pick = pick_ready(now);
                if (pick < 0)
                    break;
            end
            t_start = now;
            t_end   = t_start + job_burst[pick];
            now     = t_end;
            tat     = t_end - job_arrival[pick];
            wt      = tat - job_burst[pick];
            job_done[pick] = 1;
            tat_sum = (tat_sum + tat) & ((64'd1 << SUM_W) - 1);
            wt_sum  = (wt_sum + wt) & ((64'd1 << SUM_W) - 1);
            d            = '0;
            d.pid        = PID_W'(pick + 1);
            d.started    = CT_W'(t_start);
            d.completed  = CT_W'(t_end);
            d.turnaround = DUR_W'(tat);
            d.waiting    = DUR_W'(wt);
            d.response   = DUR_W'(t_start - job_arrival[pick]);
            set_q.push_back(d);
        end
        if (set_q.size() > 0)
        begin
            set_q[set_q.size()-1].turnaround_total = SUM_W'(tat_sum);
            set_q[set_q.size()-1].waiting_total    = SUM_W'(wt_sum);
            set_q[set_q.size()-1].last             = 1'b1;
        end
        foreach (set_q[i])
            predicted_dispatches.push_back(set_q[i]);
        foreach (job_done[i])
            job_done[i] = 0;
        job_total = 0;
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        dispatch_t want, got;
        if (!rst_n)
        begin
            job_total  = 0;
            fail_count = 0;
            foreach (job_done[i])
                job_done[i] = 0;
            predicted_dispatches.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (job_total < MAX_PROCS)
                begin
                    job_arrival[job_total] = s_tdata[15:0];
                    job_burst[job_total]   = s_tdata[31:16];
                    job_prio[job_total]    = s_tdata[39:32];
                    job_done[job_total]    = 0;
                    job_total++;
                end
                if (s_tlast)
                    schedule_job_set();
            end
            if (m_tvalid && m_tready)
            begin
                got                  = '0;
                got.pid              = m_tdata[4:0];
                got.started          = m_tdata[25:5];
                got.completed        = m_tdata[46:26];
                got.turnaround       = m_tdata[66:47];
                got.waiting          = m_tdata[86:67];
                got.response         = m_tdata[106:87];
                got.turnaround_total = m_tdata[130:107];
                got.waiting_total    = m_tdata[154:131];
                got.last             = m_tlast;
                if (predicted_dispatches.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result transfer, expected none, actual pid %0d",
                             $time, got.pid);
                end
                else
                begin
                    want = predicted_dispatches.pop_front();
                    check_field("process_id", want.pid, got.pid);
                    check_field("start_time", want.started, got.started);
                    check_field("completion_time", want.completed, got.completed);
                    check_field("turnaround_time", want.turnaround, got.turnaround);
                    check_field("waiting_time", want.waiting, got.waiting);
                    check_field("response_time", want.response, got.response);
                    check_field("total_turnaround", want.turnaround_total,
                                got.turnaround_total);
                    check_field("total_waiting", want.waiting_total, got.waiting_total);
                    check_field("m_tlast", want.last, got.last);
                end
            end
        end
        pending = predicted_dispatches.size();
    end

endmodule

// ===== tb/tb_nonpreemptive_priority_scheduler_unit.sv =====
// Testbench top: drives job sets and output stalls, and reports the verdict.
module tb_nonpreemptive_priority_scheduler_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import npsu_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int RANDOM_ITEMS  = 200;
    localparam int DRAIN_CYCLES  = 700;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned cycle_count;
    int unsigned items_sent;
    int unsigned stall_left;
    bit          calm_tail;

    nonpreemptive_priority_scheduler_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    npsu_schedule_checker u_sched_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        m_tready    = 1'b0;
        cycle_count = 0;
        items_sent  = 0;
        stall_left  = 0;
        calm_tail   = 0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result-side backpressure in bursts
    always @(negedge clk)
    begin
        if (!calm_tail && stall_left == 0 && $urandom_range(0, 4) == 0)
            stall_left = $urandom_range(1, 7);
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else
            m_tready <= 1'b1;
    end

    task automatic send_job(input logic [15:0] arr, input logic [15:0] bur,
                            input logic [7:0] pr, input bit last);
        int unsigned gap;
        if (!calm_tail && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 7);
            @(negedge clk);
            s_tvalid <= 1'b0;
            s_tdata  <= IN_DATA_W'({$urandom, $urandom});
            s_tlast  <= 1'($urandom_range(0, 1));
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {pr, bur, arr};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_random_set();
        int unsigned set_size, mode, pick_mode;
        logic [15:0] arr, bur;
        logic [7:0]  pr;
        mode = $urandom_range(0, 3);
        case ($urandom_range(0, 7))
            0:       set_size = $urandom_range(MAX_PROCS + 1, MAX_PROCS + 4);
            1:       set_size = MAX_PROCS;
            default: set_size = $urandom_range(1, 12);
        endcase
        for (int unsigned j = 0; j < set_size; j++)
        begin
            pick_mode = (mode == 3) ? $urandom_range(0, 2) : mode;
            case (pick_mode)
                0:
                begin
                    arr = 16'($urandom);
                    bur = 16'($urandom);
                    pr  = 8'($urandom);
                end
                1:
                begin
                    // crowded set: heavy contention and priority ties
                    arr = 16'($urandom_range(0, 50));
                    bur = 16'($urandom_range(0, 20));
                    pr  = 8'($urandom_range(0, 3));
                end
                default:
                begin
                    // spread arrivals, short bursts: idle jumps
                    arr = 16'($urandom);
                    bur = 16'($urandom_range(0, 255));
                    pr  = 8'($urandom_range(0, 15));
                end
            endcase
            send_job(arr, bur, pr, j == set_size - 1);
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // lone job at the top of every range, time jumps to its arrival
        send_job(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
        // identical zero-burst jobs: load order breaks the tie
        send_job(16'd0, 16'd0, 8'd0, 1'b0);
        send_job(16'd0, 16'd0, 8'd0, 1'b1);
        // full store, the extra job is dropped but still starts the schedule
        for (int i = 0; i < MAX_PROCS; i++)
            send_job(16'((i % 4) * 3), 16'(i * 2), 8'((i * 5) % 3), 1'b0);
        send_job(16'd0, 16'd1, 8'd0, 1'b1);
        // late arrivals: idle at start and again between jobs
        send_job(16'd100, 16'd5, 8'd1, 1'b0);
        send_job(16'd100, 16'd5, 8'd1, 1'b0);
        send_job(16'd300, 16'd1, 8'd0, 1'b1);

        while (items_sent < RANDOM_ITEMS)
        begin
            if (items_sent >= RANDOM_ITEMS - 20)
                calm_tail = 1;
            send_random_set();
        end
        @(negedge clk);
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
